// ===== rtl/mfuw_pkg.sv =====
// Shared types, constants and codes for the motor feedback unwrap and watchdog block.
package mfuw_pkg;

	// Encoder geometry
	localparam int ENCODER_COUNTS = 8192;
	localparam int ENCODER_HALF   = 4096;

	// Field widths
	localparam int ID_W      = 11;
	localparam int MOTOR_W   = 4;
	localparam int ANGLE_W   = 16;
	localparam int RAW_W     = 16;
	localparam int SCALE_W   = 32;
	localparam int LOST_W    = 16;
	localparam int TURN_W    = 40;
	localparam int OUT_W     = 48;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	// Angle step: difference of two angles plus one range correction
	localparam int STEP_W = ANGLE_W + 2;
	localparam logic signed [STEP_W-1:0] ENC_COUNTS_S = STEP_W'(ENCODER_COUNTS);
	localparam logic signed [STEP_W-1:0] ENC_HALF_S   = STEP_W'(ENCODER_HALF);
	localparam logic signed [STEP_W-1:0] ENC_HALF_N   = -STEP_W'(ENCODER_HALF);

	localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
	localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [LOST_W-1:0]        LOST_SAT = {LOST_W{1'b1}};

	// Position product split: low part unsigned, high part signed
	localparam int TLO_W   = TURN_W / 2;
	localparam int THI_W   = TURN_W - TLO_W;
	localparam int PLO_W   = TLO_W + 1 + SCALE_W;
	localparam int PHI_W   = THI_W + SCALE_W;
	localparam int PSUM_W  = TURN_W + SCALE_W;
	localparam int SPROD_W = RAW_W + SCALE_W;
	localparam int FRAC_SH = 8;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Reset values of the registers
	localparam logic [MOTOR_W-1:0] MOTOR_ID_RST   = MOTOR_W'(1);
	localparam logic [LOST_W-1:0]  LOST_LIMIT_RST = LOST_W'(10);

	typedef enum logic {
		OP_FRAME = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOTOR_ID    = 2'd0,
		CFG_POS_SCALE   = 2'd1,
		CFG_SPEED_SCALE = 2'd2,
		CFG_LOST_LIMIT  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic        [MOTOR_W-1:0] motor_id;
		logic signed [SCALE_W-1:0] pos_scale;
		logic signed [SCALE_W-1:0] speed_scale;
		logic        [LOST_W-1:0]  lost_limit;
	} cfg_t;

	// State snapshot after one request, handed from front to back
	typedef struct packed {
		logic signed [TURN_W-1:0] turn;
		logic signed [RAW_W-1:0]  speed;
		logic signed [RAW_W-1:0]  current;
		logic                     online;
		logic                     taken;
	} fb_rec_t;

endpackage

// ===== rtl/mfuw_if.sv =====
// Valid/ready channel interfaces for feedback requests and results.
interface mfuw_feedback_if;
	import mfuw_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     op;
	logic        [ID_W-1:0]   frame_id;
	logic        [ANGLE_W-1:0] angle_raw;
	logic signed [RAW_W-1:0]  speed_raw;
	logic signed [RAW_W-1:0]  current_raw;

	modport source (
		output valid, op, frame_id, angle_raw, speed_raw, current_raw,
		input  ready
	);
	modport sink (
		input  valid, op, frame_id, angle_raw, speed_raw, current_raw,
		output ready
	);
endinterface

interface mfuw_result_if;
	import mfuw_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] position;
	logic signed [OUT_W-1:0] speed;
	logic signed [RAW_W-1:0] current;
	logic                    online;
	logic                    frame_taken;

	modport source (
		output valid, position, speed, current, online, frame_taken,
		input  ready
	);
	modport sink (
		input  valid, position, speed, current, online, frame_taken,
		output ready
	);
endinterface

// ===== rtl/mfuw_front.sv =====
// Front end: accept requests, classify frame or tick, update unwrap and watchdog state.
module mfuw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	mfuw_feedback_if.sink        feedback,
	input  mfuw_pkg::cfg_t       cfg,
	input  logic                 q_full,
	output logic                 push,
	output mfuw_pkg::fb_rec_t    rec
);
	import mfuw_pkg::*;

	logic        [ANGLE_W-1:0] prev_angle_q, last_angle_q;
	logic signed [TURN_W-1:0]  turn_q;
	logic signed [RAW_W-1:0]   speed_q, current_q;
	logic                      ever_q, fresh_q, online_q;
	logic        [LOST_W-1:0]  lost_q;

	logic        [ANGLE_W-1:0] prev_d, last_d;
	logic signed [TURN_W-1:0]  turn_d;
	logic signed [RAW_W-1:0]   speed_d, current_d;
	logic                      ever_d, fresh_d, online_d;
	logic        [LOST_W-1:0]  lost_d, lost_inc;
	logic signed [STEP_W-1:0]  step, step_adj;
	logic signed [TURN_W:0]    turn_sum;
	logic                      match;

	assign feedback.ready = !q_full;
	assign push           = feedback.valid && feedback.ready;

	assign match = (feedback.op == OP_FRAME) && (feedback.frame_id[MOTOR_W-1:0] == cfg.motor_id);

	always_comb begin
		prev_d    = prev_angle_q;
		last_d    = last_angle_q;
		turn_d    = turn_q;
		speed_d   = speed_q;
		current_d = current_q;
		ever_d    = ever_q;
		fresh_d   = fresh_q;
		online_d  = online_q;
		lost_d    = lost_q;
		step      = '0;
		step_adj  = '0;
		turn_sum  = '0;
		lost_inc  = (lost_q == LOST_SAT) ? lost_q : lost_q + 1'b1;

		if (match) begin
			online_d  = 1'b1;
			ever_d    = 1'b1;
			fresh_d   = 1'b1;
			lost_d    = '0;
			// seed both angles on the first frame (or after a zero pair)
			if (prev_angle_q == '0 && last_angle_q == '0) begin
				prev_d = feedback.angle_raw;
			end else begin
				prev_d = last_angle_q;
			end
			last_d = feedback.angle_raw;
			step   = $signed({2'b00, last_d}) - $signed({2'b00, prev_d});
			priority if (step > ENC_HALF_S) begin
				step_adj = step - ENC_COUNTS_S;
			end else if (step < ENC_HALF_N) begin
				step_adj = step + ENC_COUNTS_S;
			end else begin
				step_adj = step;
			end
			turn_sum = (TURN_W+1)'(turn_q) + (TURN_W+1)'(step_adj);
			priority if (turn_sum[TURN_W] != turn_sum[TURN_W-1]) begin
				turn_d = turn_sum[TURN_W] ? TURN_MIN : TURN_MAX;
			end else begin
				turn_d = turn_sum[TURN_W-1:0];
			end
			speed_d   = feedback.speed_raw;
			current_d = feedback.current_raw;
		end else if (feedback.op == OP_TICK) begin
			priority if (!ever_q) begin
				online_d = 1'b0;
			end else if (fresh_q) begin
				fresh_d  = 1'b0;
				lost_d   = '0;
				online_d = 1'b1;
			end else begin
				lost_d = lost_inc;
				if (lost_inc >= cfg.lost_limit) begin
					online_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_angle_q <= '0;
			last_angle_q <= '0;
			turn_q       <= '0;
			speed_q      <= '0;
			current_q    <= '0;
			ever_q       <= 1'b0;
			fresh_q      <= 1'b0;
			online_q     <= 1'b0;
			lost_q       <= '0;
		end else if (push) begin
			prev_angle_q <= prev_d;
			last_angle_q <= last_d;
			turn_q       <= turn_d;
			speed_q      <= speed_d;
			current_q    <= current_d;
			ever_q       <= ever_d;
			fresh_q      <= fresh_d;
			online_q     <= online_d;
			lost_q       <= lost_d;
		end
	end

	always_comb begin
		rec.turn    = turn_d;
		rec.speed   = speed_d;
		rec.current = current_d;
		rec.online  = online_d;
		rec.taken   = match;
	end

`ifndef SYNTHESIS
	a_taken_online: assert property (@(posedge clk) disable iff (!arst_n)
		(push && match) |=> (online_q && ever_q && fresh_q && lost_q == '0))
		else $error("taken frame did not bring the link online");
`endif
endmodule

// ===== rtl/mfuw_queue.sv =====
// Short request queue between front and back, flop based.
module mfuw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mfuw_pkg::fb_rec_t push_rec,
	output logic              full,
	output logic              head_valid,
	input  logic              pop,
	output mfuw_pkg::fb_rec_t head_rec
);
	import mfuw_pkg::*;

	fb_rec_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");
`endif
endmodule

// ===== rtl/mfuw_back.sv =====
// Back end: scale position and speed through a stalling multiply pipeline to the result register.
module mfuw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mfuw_pkg::cfg_t    cfg,
	input  logic              head_valid,
	input  mfuw_pkg::fb_rec_t head_rec,
	output logic              pop,
	mfuw_result_if.source     result
);
	import mfuw_pkg::*;

	logic                      advance;
	logic                      v_s1, v_s2, out_vld_q;

	logic signed [PLO_W-1:0]   plo_s1;
	logic signed [PHI_W-1:0]   phi_s1;
	logic signed [SPROD_W-1:0] sprod_s1;
	logic signed [RAW_W-1:0]   cur_s1, cur_s2;
	logic                      onl_s1, onl_s2, tkn_s1, tkn_s2;

	logic signed [PSUM_W-1:0]  psum_s2;
	logic signed [OUT_W-1:0]   spd_s2;

	logic signed [PSUM_W-1:0]  psum_sh;
	logic signed [OUT_W-1:0]   pos_sat;

	logic signed [OUT_W-1:0]   pos_q, spd_q;
	logic signed [RAW_W-1:0]   cur_q;
	logic                      onl_q, tkn_q;

	// whole pipe moves together; it holds only while the result waits
	assign advance = !out_vld_q || result.ready;
	assign pop     = advance && head_valid;

	always_comb begin
		psum_sh = psum_s2 >>> FRAC_SH;
		if (psum_sh[PSUM_W-1:OUT_W-1] != {(PSUM_W-OUT_W+1){psum_sh[PSUM_W-1]}}) begin
			pos_sat = psum_sh[PSUM_W-1] ? OUT_MIN : OUT_MAX;
		end else begin
			pos_sat = psum_sh[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			plo_s1   <= $signed({1'b0, head_rec.turn[TLO_W-1:0]}) * cfg.pos_scale;
			phi_s1   <= $signed(head_rec.turn[TURN_W-1:TLO_W]) * cfg.pos_scale;
			sprod_s1 <= head_rec.speed * cfg.speed_scale;
			cur_s1   <= head_rec.current;
			onl_s1   <= head_rec.online;
			tkn_s1   <= head_rec.taken;

			psum_s2  <= (PSUM_W'(phi_s1) <<< TLO_W) + PSUM_W'(plo_s1);
			spd_s2   <= OUT_W'(sprod_s1 >>> FRAC_SH);
			cur_s2   <= cur_s1;
			onl_s2   <= onl_s1;
			tkn_s2   <= tkn_s1;

			pos_q    <= pos_sat;
			spd_q    <= spd_s2;
			cur_q    <= cur_s2;
			onl_q    <= onl_s2;
			tkn_q    <= tkn_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (advance) begin
			v_s1      <= head_valid;
			v_s2      <= v_s1;
			out_vld_q <= v_s2;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.position    = pos_q;
	assign result.speed       = spd_q;
	assign result.current     = cur_q;
	assign result.online      = onl_q;
	assign result.frame_taken = tkn_q;

`ifndef SYNTHESIS
	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !result.ready) |=> (v_s1 == $past(v_s1) && v_s2 == $past(v_s2)))
		else $error("pipeline moved while result stalled");
`endif
endmodule

// ===== rtl/motor_feedback_unwrap_watchdog_unit.sv =====
// Top level of the motor feedback unwrap and link watchdog block.
// Usage:
//   feedback channel (sink): one request per handshake, either a feedback
//   frame (op = frame) or a control tick (op = tick). A frame whose low
//   identifier nibble equals motor_id advances the multi-turn angle count,
//   latches speed and current and brings the link online. A tick runs the
//   lost-frame watchdog against lost_limit.
//   result channel (source): exactly one result per request, in order,
//   showing scaled position and speed, held current, link state and whether
//   the frame was taken.
//   cfg_write/cfg_index/cfg_data: register writes, taken at any edge with
//   cfg_write high; write them only while no request is in flight.
// Flow: one request per cycle sustained while result.ready stays high. A
//   request passes the request queue, then the partial product stage, the
//   sum stage and the result register; the 40 x 32 position product is
//   split into two partial products that the sum stage adds.
// Reset: clears the unwrap state, takes the link offline and loads the
//   register reset values; the pipeline and queue come up empty.
// Stall: while a result waits the back pipeline holds; the four-entry queue
//   keeps accepting requests until it is full, then ready drops.
module motor_feedback_unwrap_watchdog_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	mfuw_feedback_if.sink                   feedback,
	mfuw_result_if.source                   result,
	input  logic                            cfg_write,
	input  logic [mfuw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfuw_pkg::CFG_W-1:0]      cfg_data
);
	import mfuw_pkg::*;

	cfg_t    cfg_q;
	fb_rec_t push_rec, head_rec;
	logic    push, q_full, head_valid, pop;

	// Register file: decode the write index, truncate to each register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_id    <= MOTOR_ID_RST;
			cfg_q.pos_scale   <= '0;
			cfg_q.speed_scale <= '0;
			cfg_q.lost_limit  <= LOST_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MOTOR_ID:    cfg_q.motor_id    <= cfg_data[MOTOR_W-1:0];
				CFG_POS_SCALE:   cfg_q.pos_scale   <= $signed(cfg_data[SCALE_W-1:0]);
				CFG_SPEED_SCALE: cfg_q.speed_scale <= $signed(cfg_data[SCALE_W-1:0]);
				CFG_LOST_LIMIT:  cfg_q.lost_limit  <= cfg_data[LOST_W-1:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	// Front: classify each request and advance the state in order
	mfuw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.feedback (feedback),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.rec      (push_rec)
	);

	// Queue: decouple state update from the scaling pipeline
	mfuw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.head_valid (head_valid),
		.pop        (pop),
		.head_rec   (head_rec)
	);

	// Back: scale the snapshots and drive the result channel
	mfuw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.result     (result)
	);
endmodule

// ===== tb/motor_feedback_unwrap_watchdog_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the motor feedback unwrap and link watchdog block.
module motor_feedback_unwrap_watchdog_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	mfuw_feedback_if                       feedback,
	mfuw_result_if                         result,
	input  logic                           cfg_write,
	input  logic [mfuw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfuw_pkg::CFG_W-1:0]     cfg_data,
	output int                             pending,
	output int                             fails
);
	import mfuw_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0] position;
		logic signed [OUT_W-1:0] speed;
		logic signed [RAW_W-1:0] current;
		logic                    online;
		logic                    taken;
	} feedback_result_t;

	cfg_t                     regs;
	logic [ANGLE_W-1:0]       prev_ang;
	logic [ANGLE_W-1:0]       last_ang;
	logic signed [TURN_W-1:0] turns;
	logic signed [RAW_W-1:0]  speed_held;
	logic signed [RAW_W-1:0]  current_held;
	logic                     seen_frame;
	logic                     fresh;
	logic [LOST_W-1:0]        lost;
	logic                     link_up;
	feedback_result_t         result_q[$];
	int                       results_seen;

	task automatic report(input string what);
		$display("MISMATCH at result %0d: %s", results_seen, what);
		fails++;
	endtask

	// floor(value * factor / 256), clamped to the output width
	function automatic logic signed [OUT_W-1:0] scale_floor(
		input logic signed [TURN_W-1:0]  value,
		input logic signed [SCALE_W-1:0] factor
	);
		logic signed [79:0] wide_v;
		logic signed [79:0] wide_f;
		logic signed [79:0] prod;
		logic signed [79:0] lim_hi;
		logic signed [79:0] lim_lo;
		wide_v = value;
		wide_f = factor;
		prod   = (wide_v * wide_f) >>> FRAC_SH;
		lim_hi = OUT_MAX;
		lim_lo = OUT_MIN;
		if (prod > lim_hi)
			return OUT_MAX;
		if (prod < lim_lo)
			return OUT_MIN;
		return prod[OUT_W-1:0];
	endfunction

	function automatic feedback_result_t advance_unwrap(
		input op_t                     op,
		input logic [ID_W-1:0]         id,
		input logic [ANGLE_W-1:0]      ang,
		input logic signed [RAW_W-1:0] spd,
		input logic signed [RAW_W-1:0] cur
	);
		feedback_result_t r;
		int               d;
		longint           t;
		r.taken = 1'b0;
		if (op == OP_FRAME) begin
			if (id[MOTOR_W-1:0] == regs.motor_id) begin
				r.taken    = 1'b1;
				link_up    = 1'b1;
				seen_frame = 1'b1;
				fresh      = 1'b1;
				lost       = '0;
				if (prev_ang == '0 && last_ang == '0) begin
					prev_ang = ang;
				end else begin
					prev_ang = last_ang;
				end
				last_ang = ang;
				// one range correction only, even for angles past the encoder range
				d = int'(last_ang) - int'(prev_ang);
				if (d > ENCODER_HALF)
					d -= ENCODER_COUNTS;
				else if (d < -ENCODER_HALF)
					d += ENCODER_COUNTS;
				t = turns + d;
				if (t > TURN_MAX)
					t = TURN_MAX;
				if (t < TURN_MIN)
					t = TURN_MIN;
				turns        = t[TURN_W-1:0];
				speed_held   = spd;
				current_held = cur;
			end
		end else begin
			if (!seen_frame) begin
				link_up = 1'b0;
			end else if (fresh) begin
				fresh   = 1'b0;
				lost    = '0;
				link_up = 1'b1;
			end else begin
				if (lost < LOST_SAT)
					lost++;
				if (lost >= regs.lost_limit)
					link_up = 1'b0;
			end
		end
		r.position = scale_floor(turns, regs.pos_scale);
		r.speed    = scale_floor(speed_held, regs.speed_scale);
		r.current  = current_held;
		r.online   = link_up;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		feedback_result_t want;
		feedback_result_t got;
		if (!arst_n) begin
			regs.motor_id    = MOTOR_ID_RST;
			regs.pos_scale   = '0;
			regs.speed_scale = '0;
			regs.lost_limit  = LOST_LIMIT_RST;
			prev_ang         = '0;
			last_ang         = '0;
			turns            = '0;
			speed_held       = '0;
			current_held     = '0;
			seen_frame       = 1'b0;
			fresh            = 1'b0;
			lost             = '0;
			link_up          = 1'b0;
			results_seen     = 0;
			fails            = 0;
			result_q.delete();
			pending <= 0;
		end else begin
			// compare first: a result never shares an edge with its own request
			if (result.valid && result.ready) begin
				got.position = result.position;
				got.speed    = result.speed;
				got.current  = result.current;
				got.online   = result.online;
				got.taken    = result.frame_taken;
				if (result_q.size() == 0) begin
					report("result with no request outstanding");
				end else begin
					want = result_q.pop_front();
					if (got.position !== want.position)
						report($sformatf("position %0d, expected %0d",
							got.position, want.position));
					if (got.speed !== want.speed)
						report($sformatf("speed %0d, expected %0d", got.speed, want.speed));
					if (got.current !== want.current)
						report($sformatf("current %0d, expected %0d",
							got.current, want.current));
					if (got.online !== want.online)
						report($sformatf("online %b, expected %b", got.online, want.online));
					if (got.taken !== want.taken)
						report($sformatf("frame_taken %b, expected %b",
							got.taken, want.taken));
				end
				results_seen++;
			end
			if (cfg_write) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MOTOR_ID:    regs.motor_id    = cfg_data[MOTOR_W-1:0];
					CFG_POS_SCALE:   regs.pos_scale   = cfg_data;
					CFG_SPEED_SCALE: regs.speed_scale = cfg_data;
					CFG_LOST_LIMIT:  regs.lost_limit  = cfg_data[LOST_W-1:0];
				endcase
			end
			if (feedback.valid && feedback.ready)
				result_q.push_back(advance_unwrap(op_t'(feedback.op), feedback.frame_id,
					feedback.angle_raw, feedback.speed_raw, feedback.current_raw));
			pending <= result_q.size();
		end
	end

endmodule

// ===== tb/motor_feedback_unwrap_watchdog_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: stimulus, handshake idling and verdict for the motor feedback unwrap block.
module motor_feedback_unwrap_watchdog_unit_tb;
	import mfuw_pkg::*;

	// Slowest run: ~650 requests, each with the largest gap and result stall
	// and the pipeline latency; the limit allows a wide margin over it.
	localparam int CYCLE_LIMIT   = 200000;
	// Pipeline is three deep; let it settle before touching registers.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 110;
	localparam int WINDUP_FRAMES = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int                 pending;
	int                 fails;
	int                 cycle_count;
	int                 items_sent;
	bit                 calm;        // both sides run with no idling while set
	logic [MOTOR_W-1:0] motor_sel;   // motor_id currently loaded
	logic [ANGLE_W-1:0] angle_now;   // angle of the last frame sent through send_frame

	mfuw_feedback_if feedback();
	mfuw_result_if   result();

	motor_feedback_unwrap_watchdog_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.feedback  (feedback),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	motor_feedback_unwrap_watchdog_checker unwrap_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.feedback  (feedback),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.fails     (fails)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run watchdog: a hang or a lost result ends here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// Result side: stall a random number of cycles before each result,
	// none at all while the phase is calm.
	initial begin : result_sink
		int hold;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				result.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// Drive one request and hold it until the block takes it. Valid stays high
	// after acceptance so back-to-back requests need no second assignment.
	task automatic send(
		input op_t                op,
		input logic [ID_W-1:0]    id,
		input logic [ANGLE_W-1:0] ang,
		input logic [RAW_W-1:0]   spd,
		input logic [RAW_W-1:0]   cur
	);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			feedback.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feedback.valid       <= 1'b1;
		feedback.op          <= op;
		feedback.frame_id    <= id;
		feedback.angle_raw   <= ang;
		feedback.speed_raw   <= spd;
		feedback.current_raw <= cur;
		do @(posedge clk); while (!feedback.ready);
		items_sent++;
	endtask

	// Frame for our motor: random upper identifier bits, random speed and current.
	task automatic send_frame(input logic [ANGLE_W-1:0] ang);
		logic [ID_W-1:0] id;
		id = ID_W'($urandom);
		id[MOTOR_W-1:0] = motor_sel;
		angle_now = ang;
		send(OP_FRAME, id, ang, RAW_W'($urandom), RAW_W'($urandom));
	endtask

	// Frame for some other motor; it must leave every piece of state alone.
	task automatic send_foreign();
		logic [ID_W-1:0] id;
		id = ID_W'($urandom);
		id[MOTOR_W-1:0] = motor_sel + MOTOR_W'($urandom_range(1, 15));
		send(OP_FRAME, id, ANGLE_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
	endtask

	// Tick with garbage in the frame fields, which the block ignores.
	task automatic send_tick();
		send(OP_TICK, ID_W'($urandom), ANGLE_W'($urandom), RAW_W'($urandom),
			RAW_W'($urandom));
	endtask

	// Drop valid and hold off until every outstanding result has come back.
	// The first edge lets the checker count a request taken on this very step.
	task automatic drain();
		feedback.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Load all four registers with the block idle.
	task automatic load_regs(
		input logic [MOTOR_W-1:0] motor,
		input logic [SCALE_W-1:0] pos,
		input logic [SCALE_W-1:0] spd,
		input logic [LOST_W-1:0]  limit
	);
		drain();
		put_reg(CFG_MOTOR_ID, CFG_W'(motor));
		put_reg(CFG_POS_SCALE, pos);
		put_reg(CFG_SPEED_SCALE, spd);
		put_reg(CFG_LOST_LIMIT, CFG_W'(limit));
		cfg_write <= 1'b0;
		motor_sel = motor;
	endtask

	// Scale factor biased toward the extremes and toward 32'h0100_0000.
	function automatic logic [SCALE_W-1:0] pick_scale();
		case ($urandom_range(0, 4))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0100_0000;
			3:       return SCALE_W'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
			default: return SCALE_W'($urandom);
		endcase
	endfunction

	function automatic logic [LOST_W-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return LOST_W'(1);
			2:       return LOST_SAT;
			3:       return LOST_W'($urandom);
			default: return LOST_W'($urandom_range(2, 6));
		endcase
	endfunction

	// Next angle for a matching frame: often near the last one, around the half-range wrap
	// threshold or a full range on, zero, in the encoder range, or anywhere in the 16-bit field.
	function automatic logic [ANGLE_W-1:0] pick_angle();
		logic [ANGLE_W-1:0] jump;
		jump = ANGLE_W'($urandom_range(4094, 4098));
		case ($urandom_range(0, 6))
			0, 1:    return angle_now + ANGLE_W'($urandom_range(0, 600)) - ANGLE_W'(300);
			2:       return $urandom_range(0, 1) ? angle_now + jump : angle_now - jump;
			3:       return angle_now + ANGLE_W'($urandom_range(8190, 8194));
			4:       return '0;
			5:       return ANGLE_W'($urandom_range(0, ENCODER_COUNTS - 1));
			default: return ANGLE_W'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int target;
		int burst;
		int roll;

		arst_n               <= 1'b0;
		cfg_write            <= 1'b0;
		cfg_index            <= CFG_MOTOR_ID;
		cfg_data             <= '0;
		feedback.valid       <= 1'b0;
		feedback.op          <= OP_FRAME;
		feedback.frame_id    <= '0;
		feedback.angle_raw   <= '0;
		feedback.speed_raw   <= '0;
		feedback.current_raw <= '0;
		calm       = 1'b0;
		items_sent = 0;
		motor_sel  = MOTOR_ID_RST;
		angle_now  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: a tick before any frame keeps the link down,
		// a zero angle seeds nothing, a foreign frame is ignored.
		send_tick();
		send(OP_FRAME, 11'h7F1, 16'h0000, 16'h7FFF, 16'h8000);
		send(OP_FRAME, 11'h001, 16'hFFFF, 16'h0001, 16'hFFFF);
		send(OP_FRAME, 11'h7F0, 16'h1234, 16'h5555, 16'hAAAA);
		send_tick();
		send_tick();

		// Extreme scales and a lost limit of one; walk the wrap thresholds.
		load_regs(4'hF, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
		send(OP_FRAME, 11'h00F, 16'hFFFF, 16'h8000, 16'h7FFF);
		send_frame(16'h0000);    // step past the encoder range, corrected once
		send_frame(16'd4096);    // exactly half a range: no correction
		send_frame(16'h0000);
		send_frame(16'd4097);    // just past half a range: wraps
		send_frame(16'h0000);    // back to zero: just past half a range the other way, wraps
		send_frame(16'd8192);    // a full range on: corrected to no step
		send_tick();
		send_tick();             // one lost tick reaches the limit
		send_tick();
		send(OP_FRAME, 11'h7FE, 16'h4000, 16'h0000, 16'h0000);
		send_frame(16'd8000);

		// Zero lost limit: any tick without a fresh frame drops the link.
		load_regs(4'h0, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
		send(OP_FRAME, 11'h7F0, 16'd7000, 16'h8000, 16'h8000);
		send_tick();
		send_tick();

		// Random phases, each with its own register set and idling style.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_regs(MOTOR_W'($urandom), pick_scale(), pick_scale(), pick_limit());
			calm   = ($urandom_range(0, 3) == 0);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					send_frame(pick_angle());
				end else if (roll < 72) begin
					send_foreign();
				end else begin
					// runs of ticks push the lost count past small limits
					burst = $urandom_range(1, 8);
					repeat (burst) send_tick();
				end
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end

		// Wind the multi-turn count up in large steps at full scale:
		// descend in steps just over half a range, then jump back up.
		load_regs(MOTOR_W'($urandom), 32'h7FFF_FFFF, pick_scale(), LOST_LIMIT_RST);
		calm = 1'b1;
		repeat (WINDUP_FRAMES) begin
			if (angle_now > 16'd4400)
				send_frame(angle_now - ANGLE_W'($urandom_range(4097, 4300)));
			else
				send_frame(ANGLE_W'($urandom_range(61000, 65535)));
		end

		// Flip the scale sign to drive the position negative.
		load_regs(motor_sel, 32'h8000_0000, pick_scale(), 16'd2);
		calm = 1'b0;
		repeat (6) send_frame(pick_angle());
		repeat (4) send_tick();

		drain();
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mfuw_pkg.sv
rtl/mfuw_if.sv
rtl/mfuw_front.sv
rtl/mfuw_queue.sv
rtl/mfuw_back.sv
rtl/motor_feedback_unwrap_watchdog_unit.sv
tb/motor_feedback_unwrap_watchdog_checker.sv
tb/motor_feedback_unwrap_watchdog_unit_tb.sv
